>>> design/srtf_pkg.sv
// shared constants, codes and types of the shortest-remaining-time ready queue
package srtf_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [1:0] t_func;
    localparam t_func FUNC_ADD   = 2'd0;
    localparam t_func FUNC_TAKE  = 2'd1;
    localparam t_func FUNC_QUERY = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } t_rec;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] rank;
        t_rec             rec;
    } t_cand;

    typedef struct packed {
        t_status status;
        logic    found;
        t_rec    rec;
        logic    preempt;
        logic    nonempty;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH,
        ST_RESULT
    } t_state;

endpackage

>>> design/srtf_if.sv
// valid/ready channels of the ready queue: request items in, result items out
interface srtf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  job_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [15:0] remaining_time;

    modport source (output valid, func, job_id, arrival_time, burst_time, remaining_time,
                    input ready);
    modport sink   (input valid, func, job_id, arrival_time, burst_time, remaining_time,
                    output ready);
endinterface

interface srtf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        found;
    logic [7:0]  job_id_out;
    logic [15:0] arrival_out;
    logic [15:0] burst_out;
    logic [15:0] remaining_out;
    logic        preempt;
    logic        queue_nonempty;

    modport source (output valid, status, found, job_id_out, arrival_out, burst_out,
                    remaining_out, preempt, queue_nonempty, input ready);
    modport sink   (input valid, status, found, job_id_out, arrival_out, burst_out,
                    remaining_out, preempt, queue_nonempty, output ready);
endinterface

>>> design/srtf_best.sv
// running minimum over scanned slots: least remaining time, then lowest age rank
module srtf_best (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  srtf_pkg::t_cand i_cand,
    output srtf_pkg::t_cand o_best
);

    srtf_pkg::t_cand r_best;
    logic            better;

    always_comb begin
        better = i_cand.vld &&
                 (!r_best.vld ||
                  (i_cand.rec.remaining < r_best.rec.remaining) ||
                  ((i_cand.rec.remaining == r_best.rec.remaining) &&
                   (i_cand.rank < r_best.rank)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.vld <= 1'b0;
        end else if (i_clear) begin
            r_best.vld <= 1'b0;
        end else if (better) begin
            r_best <= i_cand;
        end
    end

    assign o_best = r_best;

endmodule

>>> design/srtf_ready_queue.sv
// top level of the shortest-remaining-time-first ready queue
//
//   channel | dir | handshake   | payload
//   i_in    | in  | valid/ready | func, job_id, arrival_time, burst_time, remaining_time
//   o_out   | out | valid/ready | status, found, job ids and times, preempt, queue_nonempty
//
// add and unused codes go from the idle state straight to the result state; take and query
// first scan the slot memory, one read per slot through its registered read port
// reset empties the table at once through the per-slot valid bits
// a new item is taken while a result waits in the output register
module srtf_ready_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srtf_in_if.sink    i_in,
    srtf_out_if.source o_out
);

    localparam int DEPTH = srtf_pkg::DEPTH;
    localparam int IDX_W = srtf_pkg::IDX_W;
    localparam int CNT_W = srtf_pkg::CNT_W;

    srtf_pkg::t_state r_state, n_state;

    srtf_pkg::t_rec   r_mem [DEPTH];
    srtf_pkg::t_rec   r_rd_data;
    logic [DEPTH-1:0] r_valid;
    logic [IDX_W-1:0] r_rank [DEPTH];
    logic [CNT_W-1:0] r_count;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    srtf_pkg::t_func  r_func;
    logic [15:0]      r_query_rem;

    srtf_pkg::t_res   r_res, n_res;
    srtf_pkg::t_res   r_out;
    logic             r_out_vld;

    logic             in_ready;
    logic             load_res;
    logic             start_scan;
    logic             do_add;
    logic             do_take;
    logic             load_out;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
    srtf_pkg::t_rec   wr_rec;
    srtf_pkg::t_cand  cand;
    srtf_pkg::t_cand  best;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    assign wr_rec.job_id    = i_in.job_id;
    assign wr_rec.arrival   = i_in.arrival_time;
    assign wr_rec.burst     = i_in.burst_time;
    assign wr_rec.remaining = i_in.remaining_time;

    always_comb begin
        cand.vld  = r_rd_vld && r_valid[r_rd_idx];
        cand.idx  = r_rd_idx;
        cand.rank = r_rank[r_rd_idx];
        cand.rec  = r_rd_data;
    end

    srtf_best u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (start_scan),
        .i_cand  (cand),
        .o_best  (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srtf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        in_ready   = 1'b0;
        load_res   = 1'b0;
        start_scan = 1'b0;
        do_add     = 1'b0;
        do_take    = 1'b0;
        load_out   = 1'b0;
        n_res      = '0;
        unique case (r_state)
            srtf_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    unique case (i_in.func) inside
                        srtf_pkg::FUNC_ADD: begin
                            do_add         = free_ok;
                            load_res       = 1'b1;
                            n_res.status   = free_ok ? srtf_pkg::STATUS_OK
                                                     : srtf_pkg::STATUS_FULL;
                            n_res.nonempty = free_ok || (r_count != '0);
                            n_state        = srtf_pkg::ST_RESULT;
                        end
                        srtf_pkg::FUNC_TAKE, srtf_pkg::FUNC_QUERY: begin
                            start_scan = 1'b1;
                            n_state    = srtf_pkg::ST_SCAN;
                        end
                        default: begin
                            load_res       = 1'b1;
                            n_res.nonempty = (r_count != '0);
                            n_state        = srtf_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            srtf_pkg::ST_SCAN: begin
                if (r_idx == IDX_W'(DEPTH - 1)) begin
                    n_state = srtf_pkg::ST_LAST;
                end
            end
            srtf_pkg::ST_LAST: begin
                n_state = srtf_pkg::ST_FINISH;
            end
            srtf_pkg::ST_FINISH: begin
                load_res = 1'b1;
                if (r_func == srtf_pkg::FUNC_TAKE) begin
                    if (best.vld) begin
                        do_take        = 1'b1;
                        n_res.found    = 1'b1;
                        n_res.rec      = best.rec;
                        n_res.nonempty = (r_count > CNT_W'(1));
                    end else begin
                        n_res.status = srtf_pkg::STATUS_EMPTY;
                    end
                end else begin
                    n_res.preempt  = best.vld && (best.rec.remaining < r_query_rem);
                    n_res.nonempty = (r_count != '0);
                end
                n_state = srtf_pkg::ST_RESULT;
            end
            srtf_pkg::ST_RESULT: begin
                if (!r_out_vld || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = srtf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_add) begin
            r_mem[free_idx] <= wr_rec;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // scan sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == srtf_pkg::ST_SCAN);
            if (start_scan) begin
                r_idx <= '0;
            end else if (r_state == srtf_pkg::ST_SCAN && r_idx != IDX_W'(DEPTH - 1)) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (start_scan) begin
            r_func      <= i_in.func;
            r_query_rem <= i_in.remaining_time;
        end
        if (load_res) begin
            r_res <= n_res;
        end
    end

    // occupancy and age order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (do_add) begin
            r_valid[free_idx] <= 1'b1;
            r_count           <= r_count + CNT_W'(1);
        end else if (do_take) begin
            r_valid[best.idx] <= 1'b0;
            r_count           <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_add && free_idx == IDX_W'(i)) begin
                r_rank[i] <= IDX_W'(r_count);
            end else if (do_take && r_valid[i] && r_rank[i] > best.rank) begin
                r_rank[i] <= r_rank[i] - IDX_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_vld;
    assign o_out.status         = r_out.status;
    assign o_out.found          = r_out.found;
    assign o_out.job_id_out     = r_out.rec.job_id;
    assign o_out.arrival_out    = r_out.rec.arrival;
    assign o_out.burst_out      = r_out.rec.burst;
    assign o_out.remaining_out  = r_out.rec.remaining;
    assign o_out.preempt        = r_out.preempt;
    assign o_out.queue_nonempty = r_out.nonempty;

endmodule

>>> tb/srtf_ready_queue_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the shortest-remaining-time-first ready queue
module srtf_ready_queue_test;

    localparam srtf_pkg::t_func FUNC_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 96;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_CYCLES = 2 * srtf_pkg::DEPTH + 8;

    typedef struct packed {
        srtf_pkg::t_func func;
        logic [7:0]      job_id;
        logic [15:0]     arrival;
        logic [15:0]     burst;
        logic [15:0]     remaining;
    } t_job_req;

    typedef struct packed {
        srtf_pkg::t_status status;
        logic              found;
        srtf_pkg::t_rec    job;
        logic              preempt;
        logic              nonempty;
    } t_sched_res;

    typedef struct packed {
        t_job_req   req;
        logic       typed;
        t_sched_res res;
    } t_dir_row;

    localparam t_sched_res RES_NONE = '0;

    logic i_clk;
    logic i_rst_n;

    srtf_in_if  in_if ();
    srtf_out_if out_if ();

    srtf_ready_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow of the ready table
    logic           slot_used [srtf_pkg::DEPTH];
    srtf_pkg::t_rec slot_job  [srtf_pkg::DEPTH];
    int unsigned    slot_age  [srtf_pkg::DEPTH];
    int unsigned    job_count;

    t_sched_res  pending_results [$];
    t_dir_row    directed_rows [$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    logic        hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < srtf_pkg::DEPTH; i++) begin
            slot_used[i] = 1'b0;
            slot_job[i]  = '0;
            slot_age[i]  = 0;
        end
        job_count      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_request   = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
    end

    function automatic int shortest_slot();
        int best;
        best = -1;
        for (int i = 0; i < srtf_pkg::DEPTH; i++) begin
            if (slot_used[i] && (best < 0 ||
                    slot_job[i].remaining < slot_job[best].remaining ||
                    (slot_job[i].remaining == slot_job[best].remaining &&
                     slot_age[i] < slot_age[best])))
                best = i;
        end
        return best;
    endfunction

    function automatic t_sched_res serve_request(t_job_req r);
        t_sched_res  res;
        int          best;
        int          free_idx;
        int unsigned gone_age;
        res = '0;
        unique case (r.func)
            srtf_pkg::FUNC_ADD: begin
                free_idx = -1;
                for (int i = srtf_pkg::DEPTH - 1; i >= 0; i--)
                    if (!slot_used[i]) free_idx = i;
                if (free_idx < 0) begin
                    res.status = srtf_pkg::STATUS_FULL;
                end else begin
                    slot_used[free_idx] = 1'b1;
                    slot_job[free_idx]  = '{r.job_id, r.arrival, r.burst, r.remaining};
                    slot_age[free_idx]  = job_count;
                    job_count++;
                end
            end
            srtf_pkg::FUNC_TAKE: begin
                best = shortest_slot();
                if (best < 0) begin
                    res.status = srtf_pkg::STATUS_EMPTY;
                end else begin
                    res.found = 1'b1;
                    res.job   = slot_job[best];
                    gone_age  = slot_age[best];
                    slot_used[best] = 1'b0;
                    for (int i = 0; i < srtf_pkg::DEPTH; i++)
                        if (slot_used[i] && slot_age[i] > gone_age) slot_age[i]--;
                    job_count--;
                end
            end
            srtf_pkg::FUNC_QUERY: begin
                best = shortest_slot();
                if (best >= 0 && slot_job[best].remaining < r.remaining) res.preempt = 1'b1;
            end
            default: begin
            end
        endcase
        res.nonempty = (job_count != 0);
        return res;
    endfunction

    function automatic t_job_req mk_req(srtf_pkg::t_func f, logic [7:0] id,
                                        logic [15:0] arr, logic [15:0] bur,
                                        logic [15:0] rem);
        return '{f, id, arr, bur, rem};
    endfunction

    function automatic t_sched_res mk_res(srtf_pkg::t_status s, logic fnd, logic [7:0] id,
                                          logic [15:0] arr, logic [15:0] bur,
                                          logic [15:0] rem, logic pre, logic ne);
        return '{s, fnd, '{id, arr, bur, rem}, pre, ne};
    endfunction

    task automatic add_typed(t_job_req r, t_sched_res e);
        t_dir_row row;
        row           = '{r, 1'b1, e};
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_plain(t_job_req r);
        t_dir_row row;
        row           = '{r, 1'b0, RES_NONE};
        directed_rows = {directed_rows, row};
    endtask

    task automatic load_directed();
        add_typed(mk_req(srtf_pkg::FUNC_TAKE, 8'h00, 16'h0000, 16'h0000, 16'h0000),
                  mk_res(srtf_pkg::STATUS_EMPTY, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b0));
        add_typed(mk_req(srtf_pkg::FUNC_QUERY, 8'h00, 16'h0000, 16'h0000, 16'hffff),
                  mk_res(srtf_pkg::STATUS_OK, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b0));
        add_typed(mk_req(FUNC_UNUSED, 8'hff, 16'hffff, 16'hffff, 16'hffff),
                  mk_res(srtf_pkg::STATUS_OK, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b0));
        add_typed(mk_req(srtf_pkg::FUNC_ADD, 8'hff, 16'hffff, 16'hffff, 16'hffff),
                  mk_res(srtf_pkg::STATUS_OK, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b1));
        add_typed(mk_req(srtf_pkg::FUNC_ADD, 8'h00, 16'h0000, 16'h0000, 16'h0000),
                  mk_res(srtf_pkg::STATUS_OK, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b1));
        add_typed(mk_req(srtf_pkg::FUNC_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000),
                  mk_res(srtf_pkg::STATUS_OK, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b1));
        add_typed(mk_req(srtf_pkg::FUNC_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0001),
                  mk_res(srtf_pkg::STATUS_OK, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b1, 1'b1));
        add_typed(mk_req(FUNC_UNUSED, 8'h5a, 16'h1234, 16'h5678, 16'h0000),
                  mk_res(srtf_pkg::STATUS_OK, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b1));
        add_typed(mk_req(srtf_pkg::FUNC_TAKE, 8'h00, 16'h0000, 16'h0000, 16'h0000),
                  mk_res(srtf_pkg::STATUS_OK, 1'b1, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b1));
        // fill the table with ties on remaining time
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h01, 16'h0101, 16'h1010, 16'd50));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h02, 16'h0202, 16'h2020, 16'd50));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h03, 16'h0303, 16'h3030, 16'd7));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h04, 16'h0404, 16'h4040, 16'hffff));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h05, 16'h0505, 16'h5050, 16'd50));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h06, 16'h0606, 16'h6060, 16'd7));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h07, 16'h0707, 16'h7070, 16'd0));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h08, 16'h8080, 16'h0808, 16'd1));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h09, 16'h9090, 16'h0909, 16'hffff));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h0a, 16'ha0a0, 16'h0a0a, 16'd300));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h0b, 16'hb0b0, 16'h0b0b, 16'd50));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h0c, 16'hc0c0, 16'h0c0c, 16'd2));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h0d, 16'hd0d0, 16'h0d0d, 16'd7));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h0e, 16'he0e0, 16'h0e0e, 16'd40000));
        add_plain(mk_req(srtf_pkg::FUNC_ADD, 8'h0f, 16'hf0f0, 16'h0f0f, 16'd0));
        add_typed(mk_req(srtf_pkg::FUNC_ADD, 8'h55, 16'haaaa, 16'h5555, 16'h0003),
                  mk_res(srtf_pkg::STATUS_FULL, 1'b0, 8'h00, 16'h0, 16'h0, 16'h0,
                         1'b0, 1'b1));
        add_plain(mk_req(srtf_pkg::FUNC_TAKE, 8'h00, 16'h0000, 16'h0000, 16'h0000));
        add_plain(mk_req(srtf_pkg::FUNC_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000));
    endtask

    function automatic logic [15:0] random_time();
        case ($urandom_range(0, 9))
            0:             return 16'h0000;
            1:             return 16'hffff;
            2, 3, 4, 5:    return 16'($urandom_range(0, 7));
            default:       return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_job_req random_request(int unsigned fill_goal);
        t_job_req    r;
        int unsigned pick;
        pick        = $urandom_range(0, 99);
        r.job_id    = 8'($urandom_range(0, 255));
        r.arrival   = 16'($urandom_range(0, 65535));
        r.burst     = 16'($urandom_range(0, 65535));
        r.remaining = random_time();
        if (pick < 4)
            r.func = FUNC_UNUSED;
        else if (pick < 24)
            r.func = srtf_pkg::FUNC_QUERY;
        else if (job_count < fill_goal)
            r.func = (pick < 80) ? srtf_pkg::FUNC_ADD : srtf_pkg::FUNC_TAKE;
        else
            r.func = (pick < 80) ? srtf_pkg::FUNC_TAKE : srtf_pkg::FUNC_ADD;
        return r;
    endfunction

    task automatic send_request(t_job_req r, logic typed, t_sched_res typed_res);
        t_sched_res got;
        t_sched_res want;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.func           <= r.func;
        in_if.job_id         <= r.job_id;
        in_if.arrival_time   <= r.arrival;
        in_if.burst_time     <= r.burst;
        in_if.remaining_time <= r.remaining;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        got             = serve_request(r);
        want            = typed ? typed_res : got;
        pending_results = {pending_results, want};
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: random stalls, long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sched_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result item: status %h found %b id %h", $time,
                         out_if.status, out_if.found, out_if.job_id_out);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(out_if.status));
                check_field("found", 16'(want.found), 16'(out_if.found));
                check_field("job_id_out", 16'(want.job.job_id), 16'(out_if.job_id_out));
                check_field("arrival_out", want.job.arrival, out_if.arrival_out);
                check_field("burst_out", want.job.burst, out_if.burst_out);
                check_field("remaining_out", want.job.remaining, out_if.remaining_out);
                check_field("preempt", 16'(want.preempt), 16'(out_if.preempt));
                check_field("queue_nonempty", 16'(want.nonempty), 16'(out_if.queue_nonempty));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[srtf_ready_queue] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned goal;
        goal                 = 0;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.func           <= srtf_pkg::FUNC_ADD;
        in_if.job_id         <= '0;
        in_if.arrival_time   <= '0;
        in_if.burst_time     <= '0;
        in_if.remaining_time <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_directed();
        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
                default: begin src_idle_pct = 12; snk_stall_pct = 12; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 25 == 0) goal = $urandom_range(0, srtf_pkg::DEPTH + 2);
                send_request(random_request(goal), 1'b0, RES_NONE);
            end
            if (phase == 0) begin
                // receiver holds off while items keep coming
                hold_request = 1'b1;
                for (int n = 0; n < PRESSURE_ITEMS; n++)
                    send_request(random_request(srtf_pkg::DEPTH + 2), 1'b0, RES_NONE);
            end
        end
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[srtf_ready_queue] OK");
        else
            $display("[srtf_ready_queue] ERROR");
        $finish;
    end

endmodule

>>> files.f
design/srtf_pkg.sv
design/srtf_if.sv
design/srtf_best.sv
design/srtf_ready_queue.sv
tb/srtf_ready_queue_test.sv
